/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the lease table RTL.
// Clocked, reset-qualified implication checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define SLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slt_pkg.sv */
// Shared types, codes and helpers for the suppression lease table.
// No dependencies; imported by every module of the block.
package slt_pkg;

  localparam int MaxOwners = 8;
  localparam int CfgIdxW   = 2;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  localparam logic [CfgIdxW-1:0] CFG_NC_BIT     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVALID_ID = 2'd1;

  typedef enum logic [1:0] {
    USED_KEEP    = 2'd0,
    USED_SET     = 2'd1,
    USED_CLR     = 2'd2,
    USED_CLR_ALL = 2'd3
  } used_op_e;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] body_id;
    logic [1:0]  owner;
    logic        target_present;
    logic        filter_read_ok;
    logic [31:0] current_filter;
  } req_t;

  typedef struct packed {
    logic        done_ok;
    logic        read_failed;
    logic        table_full;
    logic        owner_already_held;
    logic        first_lease;
    logic        fully_released;
    logic        filter_changed;
    logic        was_no_collide;
    logic [1:0]  lease_count;
    logic [31:0] filter_before;
    logic [31:0] filter_after;
    logic        has_lease;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  nc_bit;
    logic [31:0] invalid_id;
  } cfg_t;

  // Number of set owner bits, saturated at three.
  function automatic logic [1:0] lease_cnt(input logic [MaxOwners-1:0] mask);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < MaxOwners; i++) begin
      n = n + 4'(mask[i]);
    end
    return (n > 4'd3) ? 2'd3 : n[1:0];
  endfunction

endpackage

/* hw/rtl/slt_store.sv */
// Entry memory and used bits of the lease table.
// Depends on slt_pkg for the used-bit operation codes.
module slt_store #(
  parameter int TABLE_ENTRIES = 16,
  parameter int OWNER_COUNT   = 3,
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IdxW-1:0]        rd_addr_i,
  output logic [31:0]            rd_body_o,
  output logic [31:0]            rd_saved_o,
  output logic [OWNER_COUNT-1:0] rd_owners_o,
  output logic                   rd_was_off_o,
  output logic                   rd_used_o,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_addr_i,
  input  logic [31:0]            wr_body_i,
  input  logic [31:0]            wr_saved_i,
  input  logic [OWNER_COUNT-1:0] wr_owners_i,
  input  logic                   wr_was_off_i,
  input  slt_pkg::used_op_e      used_op_i
);
  import slt_pkg::*;

  typedef struct packed {
    logic [31:0]            body;
    logic [31:0]            saved;
    logic [OWNER_COUNT-1:0] owners;
    logic                   was_off;
  } entry_t;

  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_q;
  logic                     rd_used_q;
  logic [TABLE_ENTRIES-1:0] used_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= '{body: wr_body_i, saved: wr_saved_i,
                            owners: wr_owners_i, was_off: wr_was_off_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      rd_used_q <= used_q[rd_addr_i];
      case (used_op_i)
        USED_SET:     used_q[wr_addr_i] <= 1'b1;
        USED_CLR:     used_q[wr_addr_i] <= 1'b0;
        USED_CLR_ALL: used_q <= '0;
        default:      ;
      endcase
    end
  end

  assign rd_body_o    = rd_q.body;
  assign rd_saved_o   = rd_q.saved;
  assign rd_owners_o  = rd_q.owners;
  assign rd_was_off_o = rd_q.was_off;
  assign rd_used_o    = rd_used_q;

endmodule

/* hw/rtl/slt_ctrl.sv */
// Sequencer of the lease table: entry scan through one shared 32-bit
// comparator, then the lease decision. Depends on slt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slt_ctrl #(
  parameter int TABLE_ENTRIES = 16,
  parameter int OWNER_COUNT   = 3,
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slt_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  slt_pkg::req_t          in_word_i,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output slt_pkg::rsp_t          rsp_word_o,
  output logic [IdxW-1:0]        rd_addr_o,
  input  logic [31:0]            rd_body_i,
  input  logic [31:0]            rd_saved_i,
  input  logic [OWNER_COUNT-1:0] rd_owners_i,
  input  logic                   rd_was_off_i,
  input  logic                   rd_used_i,
  output logic                   wr_en_o,
  output logic [IdxW-1:0]        wr_addr_o,
  output logic [31:0]            wr_body_o,
  output logic [31:0]            wr_saved_o,
  output logic [OWNER_COUNT-1:0] wr_owners_o,
  output logic                   wr_was_off_o,
  output slt_pkg::used_op_e      used_op_o
);
  import slt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  rsp_t                   rsp_q, rsp_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   issue_done_q, issue_done_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic [OWNER_COUNT-1:0] hit_owners_q, hit_owners_d;
  logic [31:0]            hit_saved_q, hit_saved_d;
  logic                   hit_was_off_q, hit_was_off_d;
  logic                   free_found_q, free_found_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;

  // Shared comparator: invalid-id check at accept, body match while scanning.
  logic [31:0]            cmp_a, cmp_b;
  logic                   id_eq;

  logic [OWNER_COUNT-1:0] obit;
  logic [OWNER_COUNT-1:0] owners_new;
  logic [31:0]            nbit;
  logic [31:0]            cur;
  logic [31:0]            after;
  logic                   held;
  logic                   own_ok;

  assign id_eq  = (cmp_a == cmp_b);
  assign obit   = OWNER_COUNT'(1) << req_q.owner;
  assign nbit   = 32'(1) << cfg_i.nc_bit;
  assign cur    = req_q.current_filter;
  assign held   = hit_q && (|(hit_owners_q & obit));
  assign own_ok = {2'b00, in_word_i.owner} < 4'(OWNER_COUNT);

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    rsp_d         = rsp_q;
    rd_idx_d      = rd_idx_q;
    issue_done_d  = issue_done_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    hit_owners_d  = hit_owners_q;
    hit_saved_d   = hit_saved_q;
    hit_was_off_d = hit_was_off_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    cmp_a         = req_q.body_id;
    cmp_b         = rd_body_i;
    wr_en_o       = 1'b0;
    wr_addr_o     = hit_idx_q;
    wr_saved_o    = hit_saved_q;
    wr_was_off_o  = hit_was_off_q;
    owners_new    = hit_owners_q;
    used_op_o     = USED_KEEP;
    after         = cur;

    case (state_q)
      ST_IDLE: begin
        cmp_a = in_word_i.body_id;
        cmp_b = cfg_i.invalid_id;
        if (in_valid_i) begin
          req_d        = in_word_i;
          rsp_d        = '0;
          rd_idx_d     = '0;
          issue_done_d = 1'b0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          if (in_word_i.req_type == REQ_CLEAR) begin
            used_op_o     = USED_CLR_ALL;
            rsp_d.done_ok = 1'b1;
            state_d       = ST_RESP;
          end else if (!own_ok) begin
            state_d = ST_RESP;
          end else if (in_word_i.req_type == REQ_ACQUIRE &&
                       (!in_word_i.target_present || id_eq)) begin
            rsp_d.read_failed = 1'b1;
            state_d           = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; compare its data in the following cycle.
        if (!issue_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + IdxW'(1);
          end
        end
        if (cmp_vld_q) begin
          if (rd_used_i && id_eq) begin
            hit_d         = 1'b1;
            hit_idx_d     = cmp_idx_q;
            hit_owners_d  = rd_owners_i;
            hit_saved_d   = rd_saved_i;
            hit_was_off_d = rd_was_off_i;
            cmp_vld_d     = 1'b0;
            state_d       = ST_DECIDE;
          end else begin
            if (!rd_used_i && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = cmp_idx_q;
            end
            if (cmp_idx_q == LastIdx) begin
              cmp_vld_d = 1'b0;
              state_d   = ST_DECIDE;
            end
          end
        end
      end

      ST_DECIDE: begin
        state_d = ST_RESP;
        case (req_q.req_type)
          REQ_QUERY: begin
            rsp_d.done_ok   = 1'b1;
            rsp_d.has_lease = held;
          end
          REQ_ACQUIRE: begin
            if (held) begin
              rsp_d.done_ok            = 1'b1;
              rsp_d.owner_already_held = 1'b1;
              rsp_d.was_no_collide     = hit_was_off_q;
              rsp_d.lease_count        = lease_cnt(MaxOwners'(hit_owners_q));
              rsp_d.filter_before      = hit_saved_q;
              rsp_d.filter_after       = hit_saved_q;
            end else if (!req_q.filter_read_ok) begin
              rsp_d.read_failed = 1'b1;
            end else if (!hit_q && !free_found_q) begin
              rsp_d.table_full = 1'b1;
            end else begin
              wr_en_o = 1'b1;
              if (hit_q) begin
                owners_new = hit_owners_q | obit;
              end else begin
                wr_addr_o         = free_idx_q;
                owners_new        = obit;
                wr_saved_o        = cur;
                wr_was_off_o      = |(cur & nbit);
                used_op_o         = USED_SET;
                rsp_d.first_lease = 1'b1;
              end
              after                = cur | nbit;
              rsp_d.done_ok        = 1'b1;
              rsp_d.filter_changed = (after != cur);
              rsp_d.was_no_collide = wr_was_off_o;
              rsp_d.lease_count    = lease_cnt(MaxOwners'(owners_new));
              rsp_d.filter_before  = cur;
              rsp_d.filter_after   = after;
            end
          end
          REQ_RELEASE: begin
            if (!hit_q) begin
              rsp_d = '0;
            end else if (!req_q.target_present || !req_q.filter_read_ok) begin
              rsp_d.read_failed = 1'b1;
            end else begin
              wr_en_o    = 1'b1;
              owners_new = hit_owners_q & ~obit;
              if (|owners_new) begin
                after = cur | nbit;
              end else begin
                // Last owner gone: restore the saved bit and free the slot.
                after                = hit_was_off_q ? (cur | nbit) : (cur & ~nbit);
                rsp_d.fully_released = 1'b1;
                used_op_o            = USED_CLR;
              end
              rsp_d.done_ok        = 1'b1;
              rsp_d.filter_changed = (after != cur);
              rsp_d.was_no_collide = hit_was_off_q;
              rsp_d.lease_count    = lease_cnt(MaxOwners'(owners_new));
              rsp_d.filter_before  = cur;
              rsp_d.filter_after   = after;
            end
          end
          default: ;
        endcase
      end

      ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_idx_q     <= rd_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    rsp_q         <= rsp_d;
    cmp_idx_q     <= cmp_idx_d;
    hit_idx_q     <= hit_idx_d;
    hit_owners_q  <= hit_owners_d;
    hit_saved_q   <= hit_saved_d;
    hit_was_off_q <= hit_was_off_d;
    free_idx_q    <= free_idx_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);
  assign rsp_word_o  = rsp_q;
  assign rd_addr_o   = rd_idx_q;
  assign wr_body_o   = req_q.body_id;
  assign wr_owners_o = owners_new;

  `SLT_ASSERT_IMP(a_cmp_only_in_scan, clk_i, rst_ni, cmp_vld_q, state_q == ST_SCAN,
                  "compare stage active outside the scan")
  `SLT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
                  "accepted a second word without finishing the first")
  `SLT_ASSERT_IMP(a_new_entry_no_hit, clk_i, rst_ni, used_op_o == USED_SET, wr_en_o && !hit_q,
                  "new entry placed although the body was found")

endmodule

/* hw/rtl/suppression_lease_table.sv */
// Top level of the suppression lease table: configuration registers,
// output register, sequencer and entry store. Depends on slt_pkg,
// slt_ctrl and slt_store.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------------
//   in      | in        | in_valid_i/in_ready_o | in_word_i   (slt_pkg::req_t)
//   out     | out       | out_valid_o/out_ready_i| out_word_o (slt_pkg::rsp_t)
//   cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Clear, out-of-range owner and rejected acquire words go from idle straight to the result.
// Acquire, release and query scan the entry store one slot per cycle
// through a single 32-bit comparator; a hit ends the scan, a miss reads
// every slot, and the lease decision follows the scan.
// in_ready_o is high only between words; a finished result sits in the
// output register, so the next word is taken while the old one waits.
// Reset clears the used bits at once; there is no clearing pass.
`include "assert_macros.svh"

module suppression_lease_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int OWNER_COUNT   = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  slt_pkg::req_t                 in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output slt_pkg::rsp_t                 out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import slt_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Configuration registers; the user must send writes only while idle; the block does not enforce it.
  logic [4:0]  nc_bit_q;
  logic [31:0] inv_id_q;
  cfg_t        cfg;

  // Output register: holds the result word until the sink takes it.
  logic        out_valid_q;
  rsp_t        out_word_q;

  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp_word;

  // Store interface.
  logic [IdxW-1:0]        rd_addr;
  logic [31:0]            rd_body;
  logic [31:0]            rd_saved;
  logic [OWNER_COUNT-1:0] rd_owners;
  logic                   rd_was_off;
  logic                   rd_used;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  logic [31:0]            wr_body;
  logic [31:0]            wr_saved;
  logic [OWNER_COUNT-1:0] wr_owners;
  logic                   wr_was_off;
  used_op_e               used_op;

  assign cfg_ready_o = 1'b1;
  assign cfg         = '{nc_bit: nc_bit_q, invalid_id: inv_id_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_bit_q <= 5'd0;
      inv_id_q <= 32'hFFFF_FFFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NC_BIT:     nc_bit_q <= cfg_data_i[4:0];
        CFG_INVALID_ID: inv_id_q <= cfg_data_i;
        default:        ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance a result into the output register when it is empty or draining.
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_word_q <= rsp_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  slt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OWNER_COUNT   (OWNER_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_word_o   (rsp_word),
    .rd_addr_o    (rd_addr),
    .rd_body_i    (rd_body),
    .rd_saved_i   (rd_saved),
    .rd_owners_i  (rd_owners),
    .rd_was_off_i (rd_was_off),
    .rd_used_i    (rd_used),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_body_o    (wr_body),
    .wr_saved_o   (wr_saved),
    .wr_owners_o  (wr_owners),
    .wr_was_off_o (wr_was_off),
    .used_op_o    (used_op)
  );

  slt_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OWNER_COUNT   (OWNER_COUNT)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (rd_addr),
    .rd_body_o    (rd_body),
    .rd_saved_o   (rd_saved),
    .rd_owners_o  (rd_owners),
    .rd_was_off_o (rd_was_off),
    .rd_used_o    (rd_used),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_body_i    (wr_body),
    .wr_saved_i   (wr_saved),
    .wr_owners_i  (wr_owners),
    .wr_was_off_i (wr_was_off),
    .used_op_i    (used_op)
  );

  `SLT_ASSERT_IMP(a_first_lease_single, clk_i, rst_ni,
                  out_valid_q && out_word_q.first_lease, out_word_q.lease_count == 2'd1,
                  "new entry reported with other than one owner")
  `SLT_ASSERT_IMP(a_release_empty, clk_i, rst_ni,
                  out_valid_q && out_word_q.fully_released,
                  out_word_q.lease_count == 2'd0 && out_word_q.done_ok,
                  "entry freed while owners remain")

endmodule

/* tb/suppression_lease_table_tb.sv */
// Self-checking testbench for suppression_lease_table: a lease predictor in a
// small scoreboard class, tasks for the request and register channels and a
// process for result ready. Depends on slt_pkg and suppression_lease_table.
`timescale 1ns / 100ps

import slt_pkg::*;

// Predicts the result word of every accepted request and checks the block's
// results against those predictions in order.
class lease_scoreboard #(int ENTRIES = 16, int OWNERS = 3);
  logic [4:0]        nc_bit;
  logic [31:0]       invalid_id;
  bit                slot_used[ENTRIES];
  logic [31:0]       slot_body[ENTRIES];
  logic [31:0]       slot_saved[ENTRIES];
  logic [OWNERS-1:0] slot_owners[ENTRIES];
  bit                slot_was_set[ENTRIES];
  rsp_t              pending_rsp[$];
  int                mismatches;

  function new();
    nc_bit     = '0;
    invalid_id = '1;
    mismatches = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    if (idx == CFG_NC_BIT) nc_bit = data[4:0];
    else if (idx == CFG_INVALID_ID) invalid_id = data;
  endfunction

  function logic [1:0] lease_total(logic [OWNERS-1:0] m);
    return ($countones(m) > 3) ? 2'd3 : 2'($countones(m));
  endfunction

  function void note_request(req_t w);
    rsp_t              r;
    logic [31:0]       nmask;
    logic [31:0]       after;
    logic [OWNERS-1:0] obit;
    int                hit;
    int                slot;
    r     = '0;
    nmask = 32'd1 << nc_bit;
    hit   = -1;
    if (w.req_type == REQ_CLEAR) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      r.done_ok = 1'b1;
    end else if (w.owner < OWNERS) begin
      obit = OWNERS'(1) << w.owner;
      // Lowest used slot that holds the body wins.
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_body[i] == w.body_id) hit = i;
      end
      case (w.req_type)
        REQ_QUERY: begin
          r.done_ok   = 1'b1;
          r.has_lease = (hit >= 0) && ((slot_owners[hit] & obit) != 0);
        end
        REQ_ACQUIRE: begin
          if (!w.target_present || w.body_id == invalid_id) begin
            r.read_failed = 1'b1;
          end else if (hit >= 0 && (slot_owners[hit] & obit) != 0) begin
            r.done_ok            = 1'b1;
            r.owner_already_held = 1'b1;
            r.was_no_collide     = slot_was_set[hit];
            r.lease_count        = lease_total(slot_owners[hit]);
            r.filter_before      = slot_saved[hit];
            r.filter_after       = slot_saved[hit];
          end else if (!w.filter_read_ok) begin
            r.read_failed = 1'b1;
          end else begin
            slot = hit;
            if (slot < 0) begin
              for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!slot_used[i]) slot = i;
              end
              if (slot >= 0) begin
                slot_used[slot]    = 1'b1;
                slot_body[slot]    = w.body_id;
                slot_saved[slot]   = w.current_filter;
                slot_was_set[slot] = (w.current_filter & nmask) != 0;
                slot_owners[slot]  = obit;
                r.first_lease      = 1'b1;
              end
            end else begin
              slot_owners[slot] = slot_owners[slot] | obit;
            end
            if (slot < 0) begin
              r.table_full = 1'b1;
            end else begin
              after            = w.current_filter | nmask;
              r.done_ok        = 1'b1;
              r.filter_changed = after != w.current_filter;
              r.was_no_collide = slot_was_set[slot];
              r.lease_count    = lease_total(slot_owners[slot]);
              r.filter_before  = w.current_filter;
              r.filter_after   = after;
            end
          end
        end
        REQ_RELEASE: begin
          if (hit >= 0) begin
            if (!w.target_present || !w.filter_read_ok) begin
              r.read_failed = 1'b1;
            end else begin
              slot_owners[hit] = slot_owners[hit] & ~obit;
              r.done_ok        = 1'b1;
              r.was_no_collide = slot_was_set[hit];
              r.lease_count    = lease_total(slot_owners[hit]);
              r.filter_before  = w.current_filter;
              if (slot_owners[hit] != 0) begin
                after = w.current_filter | nmask;
              end else begin
                // Last owner gone: put back the bit as it was first seen.
                after = slot_was_set[hit] ? (w.current_filter | nmask)
                                          : (w.current_filter & ~nmask);
                r.fully_released = 1'b1;
                slot_used[hit]   = 1'b0;
              end
              r.filter_changed = after != w.current_filter;
              r.filter_after   = after;
            end
          end
        end
        default: ;
      endcase
    end
    pending_rsp = {pending_rsp, r};
  endfunction

  function void check_response(rsp_t got);
    rsp_t  want;
    string diff;
    diff = "";
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: unexpected result word %h", $time, got);
    end else begin
      want = pending_rsp.pop_front();
      if (got.done_ok !== want.done_ok) diff = {diff, " done_ok"};
      if (got.read_failed !== want.read_failed) diff = {diff, " read_failed"};
      if (got.table_full !== want.table_full) diff = {diff, " table_full"};
      if (got.owner_already_held !== want.owner_already_held)
        diff = {diff, " owner_already_held"};
      if (got.first_lease !== want.first_lease) diff = {diff, " first_lease"};
      if (got.fully_released !== want.fully_released) diff = {diff, " fully_released"};
      if (got.filter_changed !== want.filter_changed) diff = {diff, " filter_changed"};
      if (got.was_no_collide !== want.was_no_collide) diff = {diff, " was_no_collide"};
      if (got.lease_count !== want.lease_count) diff = {diff, " lease_count"};
      if (got.filter_before !== want.filter_before) diff = {diff, " filter_before"};
      if (got.filter_after !== want.filter_after) diff = {diff, " filter_after"};
      if (got.has_lease !== want.has_lease) diff = {diff, " has_lease"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch in%s: expected %h actual %h", $time, diff, want, got);
      end
    end
  endfunction
endclass

module suppression_lease_table_tb;

  localparam int TableEntries = 16;
  localparam int OwnerCount   = 3;
  localparam int PhaseCount   = 6;
  localparam int PhaseWords   = 225;
  localparam int PoolDepth    = 24;
  // Leave a margin after the last result, past the worst scan.
  localparam int SettleCycles = TableEntries + 8;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 400000;
  // Register indexes beyond the two defined ones; the block ignores them.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  req_t               in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rsp_t               out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  lease_scoreboard #(TableEntries, OwnerCount) sb;

  // Stimulus knobs and the watchdog count; calm and hold_off_req are shared with the receiver process.
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int          cycle_count = 0;
  logic [31:0] body_pool[PoolDepth];
  int          pool_span = PoolDepth;

  suppression_lease_table #(
    .TABLE_ENTRIES(TableEntries),
    .OWNER_COUNT  (OwnerCount)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every result word taken at an edge; both signals are pre-edge values.
  always @(posedge clk_i) begin
    if (out_valid === 1'b1 && out_ready) sb.check_response(out_word);
  end

  // Drive out_ready: random stalls, none while calm, and one long hold-off
  // on request so the output register fills and the block stalls its input.
  initial begin : result_ready_gen
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_left    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic req_t make_req(req_e kind, logic [31:0] id, logic [1:0] own,
                                    bit present, bit read_ok, logic [31:0] filt);
    req_t w;
    w.req_type       = kind;
    w.body_id        = id;
    w.owner          = own;
    w.target_present = present;
    w.filter_read_ok = read_ok;
    w.current_filter = filt;
    return w;
  endfunction

  // Mostly lease traffic on a small pool of bodies, so entries fill up, gain
  // and lose owners; the rest is stray ids, the rejected id and bad owners.
  function automatic req_t rand_request();
    req_t w;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 45) w.req_type = REQ_ACQUIRE;
    else if (pick < 77) w.req_type = REQ_RELEASE;
    else if (pick < 99) w.req_type = REQ_QUERY;
    else w.req_type = REQ_CLEAR;
    pick = $urandom_range(99);
    if (pick < 85) w.body_id = body_pool[$urandom_range(pool_span - 1)];
    else if (pick < 90) w.body_id = sb.invalid_id;
    else w.body_id = $urandom;
    w.owner = ($urandom_range(99) < 4) ? 2'(OwnerCount) : 2'($urandom_range(OwnerCount - 1));
    w.target_present = $urandom_range(99) < 95;
    w.filter_read_ok = $urandom_range(99) < 93;
    pick = $urandom_range(99);
    if (pick < 10) w.current_filter = '0;
    else if (pick < 20) w.current_filter = '1;
    else w.current_filter = $urandom;
    return w;
  endfunction

  // Offer one request word and hold it until taken; leave valid high so a
  // back-to-back word needs no second assignment in the same step.
  task automatic send_request(req_t w);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    sb.note_request(w);
  endtask

  // Offer one register write and hold it until taken; valid stays high so
  // writes can follow back to back, and the caller drops it afterwards.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Drop valid and wait until every predicted result has come back, then
  // let the block settle before touching registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    req_t        directed[$];
    logic [31:0] body_a;
    logic [31:0] body_b;
    sb     = new();
    body_a = 32'h1234_5678;
    body_b = 32'h8000_0001;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed pass on reset settings: every request kind and corner case.
    directed = {directed, make_req(REQ_QUERY,   body_a, 2'd0, 1, 1, 32'h0)};
    // release of a body that is not in the table
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd0, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd0, 0, 1, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, 32'hFFFF_FFFF, 2'd0, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd0, 1, 0, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd0, 1, 1, 32'hAAAA_AAAA)};
    // owner already holds: answered from the entry even with a failed read
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd0, 1, 0, 32'h5555_5555)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd1, 1, 1, 32'hAAAA_AAAB)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'd2, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_QUERY,   body_a, 2'd1, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, body_a, 2'(OwnerCount), 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd1, 0, 1, 32'h0)};
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd1, 1, 0, 32'h0)};
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd1, 1, 1, 32'hFFFF_FFFE)};
    // release by an owner that no longer holds the body
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd1, 1, 1, 32'h0000_0001)};
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd0, 1, 1, 32'h0000_0001)};
    directed = {directed, make_req(REQ_RELEASE, body_a, 2'd2, 1, 1, 32'hFFFF_FFFF)};
    directed = {directed, make_req(REQ_ACQUIRE, body_b, 2'd0, 1, 1, 32'hFFFF_FFFF)};
    directed = {directed, make_req(REQ_RELEASE, body_b, 2'd0, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_ACQUIRE, 32'h0, 2'd2, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_RELEASE, 32'h0, 2'(OwnerCount), 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_QUERY,   32'h0, 2'(OwnerCount), 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_CLEAR,   32'h0, 2'd0, 1, 1, 32'h0)};
    directed = {directed, make_req(REQ_QUERY,   32'h0, 2'd2, 1, 1, 32'h0)};
    foreach (directed[i]) send_request(directed[i]);
    drain();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // Reprogram while idle: mostly extremes, random settings in phases 2 and 5.
      case (phase)
        0: begin
          write_reg(CFG_NC_BIT, 32'd0);
          write_reg(CFG_INVALID_ID, 32'hFFFF_FFFF);
          write_reg(CFG_SPARE_A, $urandom);
          write_reg(CFG_SPARE_B, $urandom);
        end
        1: begin
          write_reg(CFG_NC_BIT, 32'd31);
          write_reg(CFG_INVALID_ID, 32'h0);
        end
        2: begin
          // upper data bits are don't-care for the bit position
          write_reg(CFG_NC_BIT, $urandom);
          write_reg(CFG_INVALID_ID, $urandom);
        end
        3: begin
          write_reg(CFG_NC_BIT, 32'd31);
          write_reg(CFG_INVALID_ID, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(CFG_NC_BIT, 32'd0);
          write_reg(CFG_INVALID_ID, 32'h0);
        end
        default: begin
          write_reg(CFG_NC_BIT, $urandom_range(1, 30));
          write_reg(CFG_INVALID_ID, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;

      // Small pools stack owners on few bodies; large ones overflow the table.
      pool_span = (phase % 2 == 1) ? 6 : PoolDepth;
      foreach (body_pool[i]) body_pool[i] = $urandom;
      body_pool[0] = 32'h0;
      body_pool[1] = sb.invalid_id;
      calm = (phase == 2);
      if (phase == 4) hold_off_req = 1'b1;

      for (int n = 0; n < PhaseWords; n++) send_request(rand_request());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
